// ----- hw/rtl/ptpe_pkg.sv -----
// Shared types, sizes and helpers of the planar tile pattern encoder.
// No dependencies; every other file of the block refers to this package.
package ptpe_pkg;

  localparam int unsigned ImageSide    = 128;
  localparam int unsigned TileSide     = 8;
  localparam int unsigned PixPerWord   = 8;
  localparam int unsigned PixelCount   = ImageSide * ImageSide;
  localparam int unsigned StoreWords   = PixelCount / PixPerWord;
  localparam int unsigned TilesPerRow  = ImageSide / TileSide;
  localparam int unsigned BytesPerTile = 2 * TileSide;
  localparam int unsigned TableBytes   = TilesPerRow * TilesPerRow * BytesPerTile;

  localparam int unsigned LoadPosW  = $clog2(PixelCount);
  localparam int unsigned FetchPosW = $clog2(TableBytes);
  localparam int unsigned AddrW     = $clog2(StoreWords);
  localparam int unsigned TileW     = $clog2(TilesPerRow);
  localparam int unsigned RowW      = $clog2(TileSide);
  localparam int unsigned FillW     = $clog2(PixPerWord);
  localparam int unsigned WordW     = 2 * PixPerWord;

  localparam logic [7:0] ChanZero = 8'd0;
  localparam logic [7:0] ChanFull = 8'd255;

  localparam logic [1:0] IdxBlack = 2'd0;
  localparam logic [1:0] IdxWhite = 2'd1;
  localparam logic [1:0] IdxRed   = 2'd2;
  localparam logic [1:0] IdxBlue  = 2'd3;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncFetch = 1'b1;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [WordW-1:0] word_t;

  // Write request from the load packer to the pixel store.
  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } wr_req_t;

  // Partly filled word that has not reached the store yet.
  typedef struct packed {
    logic             match;
    logic [FillW-1:0] fill;
    word_t            pix;
  } fwd_t;

  typedef struct packed {
    logic       bad;
    logic [1:0] idx;
  } color_t;

  function automatic color_t color_index(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    color_t c;
    c.bad = 1'b0;
    if (r == ChanZero && g == ChanZero && b == ChanZero) begin
      c.idx = IdxBlack;
    end else if (r == ChanFull && g == ChanFull && b == ChanFull) begin
      c.idx = IdxWhite;
    end else if (r == ChanFull && g == ChanZero && b == ChanZero) begin
      c.idx = IdxRed;
    end else if (r == ChanZero && g == ChanZero && b == ChanFull) begin
      c.idx = IdxBlue;
    end else begin
      c.idx = IdxBlack;
      c.bad = 1'b1;
    end
    return c;
  endfunction

  // One bitplane of a stored word, leftmost pixel (lowest bits) in the MSB.
  function automatic logic [7:0] plane_byte(word_t w, logic plane);
    logic [7:0] b;
    for (int k = 0; k < PixPerWord; k++) begin
      b[PixPerWord-1-k] = w[2*k + int'(plane)];
    end
    return b;
  endfunction

endpackage

// ----- hw/rtl/ptpe_pixel_store.sv -----
// Pixel store of the tile pattern encoder: one write port and one read port
// with registered read data. Depends on ptpe_pkg.
module ptpe_pixel_store (
  input  logic              clk_i,
  input  ptpe_pkg::wr_req_t wr_i,
  input  logic              rd_en_i,
  input  ptpe_pkg::addr_t   rd_addr_i,
  output ptpe_pkg::word_t   rd_data_o
);

  ptpe_pkg::word_t mem [ptpe_pkg::StoreWords];
  ptpe_pkg::word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hw/rtl/ptpe_load_packer.sv -----
// Load side: maps pixels to indices, packs eight into a word and writes the
// full word to the store. Keeps the sticky bad color flag. Depends on ptpe_pkg.
module ptpe_load_packer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_en_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  ptpe_pkg::addr_t   fetch_addr_i,
  output ptpe_pkg::wr_req_t wr_o,
  output ptpe_pkg::fwd_t    fwd_o,
  output logic              flag_next_o
);

  logic [ptpe_pkg::LoadPosW-1:0] pos_q, pos_d;
  ptpe_pkg::word_t               buf_q, buf_d;
  logic                          bad_q, bad_d;
  ptpe_pkg::color_t              color;
  logic [ptpe_pkg::FillW-1:0]    fill;

  assign color = ptpe_pkg::color_index(red_i, green_i, blue_i);
  assign fill  = pos_q[ptpe_pkg::FillW-1:0];

  always_comb begin
    pos_d = pos_q;
    buf_d = buf_q;
    bad_d = bad_q;
    if (load_en_i) begin
      buf_d[{fill, 1'b0} +: 2] = color.idx;
      bad_d = bad_q | color.bad;
      if (pos_q == ptpe_pkg::LoadPosW'(ptpe_pkg::PixelCount - 1)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + ptpe_pkg::LoadPosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      bad_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      bad_q <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  // The word goes to the store together with the eighth pixel.
  assign wr_o.en   = load_en_i && (fill == ptpe_pkg::FillW'(ptpe_pkg::PixPerWord - 1));
  assign wr_o.addr = pos_q[ptpe_pkg::LoadPosW-1:ptpe_pkg::FillW];
  assign wr_o.data = {color.idx, buf_q[ptpe_pkg::WordW-3:0]};

  assign fwd_o.match = (fetch_addr_i == pos_q[ptpe_pkg::LoadPosW-1:ptpe_pkg::FillW]);
  assign fwd_o.fill  = fill;
  assign fwd_o.pix   = buf_q;

  assign flag_next_o = bad_d;

endmodule

// ----- hw/rtl/ptpe_fetch_seq.sv -----
// Fetch side: walks the pattern table and turns each byte position into a
// store word address and a bitplane. Depends on ptpe_pkg.
module ptpe_fetch_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fetch_en_i,
  output ptpe_pkg::addr_t addr_o,
  output logic            plane_o,
  output logic            last_o
);

  localparam int unsigned PlaneBit = ptpe_pkg::RowW;
  localparam int unsigned TxLo     = ptpe_pkg::RowW + 1;

  logic [ptpe_pkg::FetchPosW-1:0] pos_q, pos_d;

  // Byte position is {tile y, tile x, plane, row}; the word holding that
  // row is {tile y, row, tile x}.
  assign addr_o  = {pos_q[ptpe_pkg::FetchPosW-1 -: ptpe_pkg::TileW],
                    pos_q[ptpe_pkg::RowW-1:0],
                    pos_q[TxLo +: ptpe_pkg::TileW]};
  assign plane_o = pos_q[PlaneBit];
  assign last_o  = (pos_q == ptpe_pkg::FetchPosW'(ptpe_pkg::TableBytes - 1));

  always_comb begin
    pos_d = pos_q;
    if (fetch_en_i) begin
      pos_d = last_o ? '0 : pos_q + ptpe_pkg::FetchPosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ----- hw/rtl/planar_tile_pattern_encoder_unit.sv -----
// Planar tile pattern encoder, top level. Depends on ptpe_pkg, ptpe_pixel_store,
// ptpe_load_packer and ptpe_fetch_seq.
// Each accepted word is loaded into stage one at its accepting edge and moves to
// the output register once it is free. Throughput: one word per cycle, loads and
// fetches alike, while the output is taken; set by the single read port of the
// pixel store and one full-word write per eight loaded pixels.
// Reset clears the load and fetch counters, the sticky flag and the pipeline
// valids; the pixel store is not cleared and holds garbage until loaded.
module planar_tile_pattern_encoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] pattern_byte_o,
  output logic       invalid_color_o,
  output logic       last_byte_o
);

  // Stage one holds an accepted word while the store read is in flight.
  // The output register then holds the finished result until it is taken.
  logic in_fire, out_free, s1_move;
  logic load_en, fetch_en;

  ptpe_pkg::wr_req_t wr;
  ptpe_pkg::fwd_t    fwd;
  ptpe_pkg::addr_t   fetch_addr;
  ptpe_pkg::word_t   rd_data;
  logic              fetch_plane, fetch_last, flag_next;

  logic           s1_valid_q;
  logic           s1_fetch_q, s1_plane_q, s1_last_q, s1_flag_q;
  ptpe_pkg::fwd_t s1_fwd_q;

  logic       out_valid_q;
  logic [7:0] pattern_q;
  logic       flag_q, last_q;

  ptpe_pkg::word_t merged;
  logic [7:0]      s1_byte;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_en    = in_fire && (func_i == ptpe_pkg::FuncLoad);
  assign fetch_en   = in_fire && (func_i == ptpe_pkg::FuncFetch);

  ptpe_load_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_en_i   (load_en),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .fetch_addr_i(fetch_addr),
    .wr_o        (wr),
    .fwd_o       (fwd),
    .flag_next_o (flag_next)
  );

  ptpe_fetch_seq u_fetch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fetch_en_i(fetch_en),
    .addr_o    (fetch_addr),
    .plane_o   (fetch_plane),
    .last_o    (fetch_last)
  );

  // Loads write at their own accept edge and a fetch reads at a later edge,
  // so a read never meets a write to the same word in one cycle.
  ptpe_pixel_store u_store (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .rd_en_i  (fetch_en),
    .rd_addr_i(fetch_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_fetch_q <= (func_i == ptpe_pkg::FuncFetch);
      s1_plane_q <= fetch_plane;
      s1_last_q  <= fetch_last;
      s1_flag_q  <= flag_next;
      s1_fwd_q   <= fwd;
    end
    if (s1_move) begin
      pattern_q <= s1_fetch_q ? s1_byte : 8'd0;
      flag_q    <= s1_flag_q;
      last_q    <= s1_fetch_q && s1_last_q;
    end
  end

  // Pixels loaded into a word that has not been written back yet come from
  // the snapshot of the packing buffer; the rest come from the store.
  always_comb begin
    merged = rd_data;
    for (int k = 0; k < ptpe_pkg::PixPerWord; k++) begin
      if (s1_fwd_q.match && (ptpe_pkg::FillW'(k) < s1_fwd_q.fill)) begin
        merged[2*k +: 2] = s1_fwd_q.pix[2*k +: 2];
      end
    end
  end

  assign s1_byte = ptpe_pkg::plane_byte(merged, s1_plane_q);

  assign out_valid_o     = out_valid_q;
  assign pattern_byte_o  = pattern_q;
  assign invalid_color_o = flag_q;
  assign last_byte_o     = last_q;

  // A stalled stage-one word must not be dropped.
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q)
    else $error("stage one word lost under stall");

  // The store never sees a write and a read in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr.en && fetch_en))
    else $error("store write and read in one cycle");

  // A load result carries a zero pattern and no last marker.
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && !s1_fetch_q |=> pattern_byte_o == 8'd0 && !last_byte_o)
    else $error("load result with nonzero pattern or last marker");

  // The invalid flag is sticky from one result to the next.
  a_flag_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && flag_q |=> flag_q)
    else $error("invalid color flag cleared");

endmodule

// ----- sim/planar_tile_pattern_encoder_unit_tb.sv -----
// Self-checking testbench for planar_tile_pattern_encoder_unit.
// Depends on ptpe_pkg and the encoder RTL. It streams pixel and fetch words and
// checks each result word against a scoreboard that keeps its own image copy.
module planar_tile_pattern_encoder_unit_tb;

  localparam int unsigned CycleLimit  = 1_500_000;
  localparam int unsigned LoadTarget  = 420;
  localparam int unsigned RandomWords = 300;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned HoldEvery   = 400;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned DrainCycles = 8;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       func      = ptpe_pkg::FuncLoad;
  logic [7:0] red       = 8'd0;
  logic [7:0] green     = 8'd0;
  logic [7:0] blue      = 8'd0;
  logic       out_ready = 1'b0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] pattern_byte_o;
  logic       invalid_color_o;
  logic       last_byte_o;

  planar_tile_pattern_encoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .func_i          (func),
    .red_i           (red),
    .green_i         (green),
    .blue_i          (blue),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .pattern_byte_o  (pattern_byte_o),
    .invalid_color_o (invalid_color_o),
    .last_byte_o     (last_byte_o)
  );

  typedef struct {
    logic [7:0] pattern;
    logic       invalid;
    logic       last;
  } encoder_word_t;

  // Keeps its own copy of the image and both counters, and queues the result
  // word that each accepted input word should produce.
  class pattern_scoreboard;
    logic [1:0]    pixel_idx [ptpe_pkg::PixelCount];
    int unsigned   load_pos;
    int unsigned   fetch_pos;
    logic          bad_seen;
    encoder_word_t awaited [$];
    int unsigned   errors;

    function new();
      load_pos  = 0;
      fetch_pos = 0;
      bad_seen  = 1'b0;
      errors    = 0;
    endfunction

    function void note_word(logic f, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      encoder_word_t e;
      logic [1:0]    idx;
      logic [7:0]    acc;
      int unsigned   tile, tile_byte, plane, row, y, x;
      e.pattern = 8'd0;
      e.last    = 1'b0;
      if (f == ptpe_pkg::FuncLoad) begin
        if (r == ptpe_pkg::ChanZero && g == ptpe_pkg::ChanZero &&
            b == ptpe_pkg::ChanZero) begin
          idx = ptpe_pkg::IdxBlack;
        end else if (r == ptpe_pkg::ChanFull && g == ptpe_pkg::ChanFull &&
                     b == ptpe_pkg::ChanFull) begin
          idx = ptpe_pkg::IdxWhite;
        end else if (r == ptpe_pkg::ChanFull && g == ptpe_pkg::ChanZero &&
                     b == ptpe_pkg::ChanZero) begin
          idx = ptpe_pkg::IdxRed;
        end else if (r == ptpe_pkg::ChanZero && g == ptpe_pkg::ChanZero &&
                     b == ptpe_pkg::ChanFull) begin
          idx = ptpe_pkg::IdxBlue;
        end else begin
          // Any other color raises the sticky flag and is stored as black.
          idx      = ptpe_pkg::IdxBlack;
          bad_seen = 1'b1;
        end
        pixel_idx[load_pos] = idx;
        load_pos = (load_pos + 1) % ptpe_pkg::PixelCount;
      end else begin
        // Each tile gives its low-plane rows first, then its high-plane rows;
        // the leftmost pixel of a row lands in the MSB.
        tile      = fetch_pos / ptpe_pkg::BytesPerTile;
        tile_byte = fetch_pos % ptpe_pkg::BytesPerTile;
        plane     = tile_byte / ptpe_pkg::TileSide;
        row       = tile_byte % ptpe_pkg::TileSide;
        y         = (tile / ptpe_pkg::TilesPerRow) * ptpe_pkg::TileSide + row;
        x         = (tile % ptpe_pkg::TilesPerRow) * ptpe_pkg::TileSide;
        acc       = 8'd0;
        for (int k = 0; k < ptpe_pkg::TileSide; k++) begin
          acc = {acc[6:0], pixel_idx[y * ptpe_pkg::ImageSide + x + k][plane]};
        end
        e.pattern = acc;
        e.last    = (fetch_pos == ptpe_pkg::TableBytes - 1);
        fetch_pos = (fetch_pos + 1) % ptpe_pkg::TableBytes;
      end
      e.invalid = bad_seen;
      awaited.push_back(e);
    endfunction

    function void check_word(logic [7:0] pattern, logic invalid, logic last);
      encoder_word_t e;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= ReportLimit) begin
          $display("unexpected result word: pattern %02h flag %b last %b",
                   pattern, invalid, last);
        end
        return;
      end
      e = awaited.pop_front();
      if (pattern !== e.pattern || invalid !== e.invalid || last !== e.last) begin
        errors++;
        if (errors <= ReportLimit) begin
          $display("result mismatch: expected pattern %02h flag %b last %b, got %02h %b %b",
                   e.pattern, e.invalid, e.last, pattern, invalid, last);
        end
      end
    endfunction
  endclass

  pattern_scoreboard sb = new();

  // Stimulus-side view of the counters, used to keep every fetch on pixels
  // that were already written since reset.
  int unsigned loads_sent  = 0;
  int unsigned fetch_next  = 0;
  int unsigned burst_left  = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Both handshakes are sampled at the edge, before any driven value moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        sb.note_word(func, red, green, blue);
      end
      if (out_valid_o && out_ready) begin
        sb.check_word(pattern_byte_o, invalid_color_o, last_byte_o);
      end
    end
  end

  // A fetch of byte f reads one row of eight pixels; it is safe once that row
  // segment has been loaded.
  function automatic bit rows_ready(int unsigned f);
    int unsigned tile, row, y, x, written;
    tile    = f / ptpe_pkg::BytesPerTile;
    row     = (f % ptpe_pkg::BytesPerTile) % ptpe_pkg::TileSide;
    y       = (tile / ptpe_pkg::TilesPerRow) * ptpe_pkg::TileSide + row;
    x       = (tile % ptpe_pkg::TilesPerRow) * ptpe_pkg::TileSide;
    written = (loads_sent < ptpe_pkg::PixelCount) ? loads_sent : ptpe_pkg::PixelCount;
    return written >= y * ptpe_pkg::ImageSide + x + ptpe_pkg::TileSide;
  endfunction

  task automatic send_word(input logic f, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    in_valid <= 1'b1;
    func     <= f;
    red      <= r;
    green    <= g;
    blue     <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Words go out in bursts; between bursts the sender may sit idle a while.
  task automatic offer(input logic f, input logic [7:0] r, input logic [7:0] g,
                       input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    if (f == ptpe_pkg::FuncFetch) begin
      fetch_next = (fetch_next + 1) % ptpe_pkg::TableBytes;
    end else begin
      loads_sent++;
    end
    send_word(f, r, g, b);
  endtask

  task automatic random_word(input int unsigned fetch_pct, input int unsigned noise_pct);
    logic [7:0] r, g, b;
    logic [1:0] pick;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    if ($urandom_range(0, 99) < fetch_pct && rows_ready(fetch_next)) begin
      offer(ptpe_pkg::FuncFetch, r, g, b);
    end else begin
      if ($urandom_range(0, 99) >= noise_pct) begin
        pick = 2'($urandom);
        case (pick)
          ptpe_pkg::IdxBlack: {r, g, b} = {ptpe_pkg::ChanZero, ptpe_pkg::ChanZero,
                                           ptpe_pkg::ChanZero};
          ptpe_pkg::IdxWhite: {r, g, b} = {ptpe_pkg::ChanFull, ptpe_pkg::ChanFull,
                                           ptpe_pkg::ChanFull};
          ptpe_pkg::IdxRed:   {r, g, b} = {ptpe_pkg::ChanFull, ptpe_pkg::ChanZero,
                                           ptpe_pkg::ChanZero};
          default:            {r, g, b} = {ptpe_pkg::ChanZero, ptpe_pkg::ChanZero,
                                           ptpe_pkg::ChanFull};
        endcase
      end
      offer(ptpe_pkg::FuncLoad, r, g, b);
    end
  endtask

  // Stops offering words until every expected result word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.awaited.size() != 0);
  endtask

  // The receiver changes its acceptance rate from span to span and now
  // and then refuses everything for a long stretch so the block backs up.
  initial begin : receiver
    int unsigned duty, span, since_hold;
    since_hold = 0;
    wait (rst_ni);
    forever begin
      if (since_hold >= HoldEvery) begin
        repeat (HoldCycles) begin
          @(posedge clk_i);
          out_ready <= 1'b0;
        end
        since_hold = 0;
      end
      span = $urandom_range(16, 96);
      duty = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(10, 90);
      repeat (span) begin
        @(posedge clk_i);
        out_ready <= ($urandom_range(1, 100) <= duty);
      end
      since_hold += span;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The four colors, then a fetch of the first row once its eight pixels
    // are in. The flag must still read low through all of these.
    offer(ptpe_pkg::FuncLoad, ptpe_pkg::ChanZero, ptpe_pkg::ChanZero, ptpe_pkg::ChanZero);
    offer(ptpe_pkg::FuncLoad, ptpe_pkg::ChanFull, ptpe_pkg::ChanFull, ptpe_pkg::ChanFull);
    offer(ptpe_pkg::FuncLoad, ptpe_pkg::ChanFull, ptpe_pkg::ChanZero, ptpe_pkg::ChanZero);
    offer(ptpe_pkg::FuncLoad, ptpe_pkg::ChanZero, ptpe_pkg::ChanZero, ptpe_pkg::ChanFull);
    offer(ptpe_pkg::FuncLoad, ptpe_pkg::ChanZero, ptpe_pkg::ChanZero, ptpe_pkg::ChanFull);
    offer(ptpe_pkg::FuncLoad, ptpe_pkg::ChanFull, ptpe_pkg::ChanZero, ptpe_pkg::ChanZero);
    offer(ptpe_pkg::FuncLoad, ptpe_pkg::ChanFull, ptpe_pkg::ChanFull, ptpe_pkg::ChanFull);
    offer(ptpe_pkg::FuncLoad, ptpe_pkg::ChanZero, ptpe_pkg::ChanZero, ptpe_pkg::ChanZero);
    offer(ptpe_pkg::FuncFetch, ptpe_pkg::ChanFull, ptpe_pkg::ChanFull, ptpe_pkg::ChanFull);

    // Colors that are none of the four legal ones, many one step away from a
    // legal one; each must raise the flag and be stored as black.
    offer(ptpe_pkg::FuncLoad, 8'd0, 8'd0, 8'd1);
    offer(ptpe_pkg::FuncLoad, 8'd0, 8'd1, 8'd0);
    offer(ptpe_pkg::FuncLoad, 8'd1, 8'd0, 8'd0);
    offer(ptpe_pkg::FuncLoad, 8'd254, 8'd255, 8'd255);
    offer(ptpe_pkg::FuncLoad, 8'd255, 8'd254, 8'd255);
    offer(ptpe_pkg::FuncLoad, 8'd255, 8'd255, 8'd254);
    offer(ptpe_pkg::FuncLoad, 8'd255, 8'd1, 8'd0);
    offer(ptpe_pkg::FuncLoad, 8'd255, 8'd0, 8'd1);
    offer(ptpe_pkg::FuncLoad, 8'd0, 8'd0, 8'd254);
    offer(ptpe_pkg::FuncLoad, 8'd1, 8'd0, 8'd255);
    offer(ptpe_pkg::FuncLoad, 8'd0, 8'd255, 8'd0);
    offer(ptpe_pkg::FuncLoad, 8'd255, 8'd255, 8'd0);
    offer(ptpe_pkg::FuncLoad, 8'd0, 8'd255, 8'd255);
    offer(ptpe_pkg::FuncLoad, 8'd255, 8'd0, 8'd255);
    offer(ptpe_pkg::FuncLoad, 8'd128, 8'd128, 8'd128);

    // Fill the top rows of the image with fetches interleaved as rows become
    // ready, then a mixed random stretch.
    while (loads_sent < LoadTarget) random_word(25, 3);
    drain();
    repeat (RandomWords) random_word(50, 15);

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ptpe_pkg.sv
hw/rtl/ptpe_pixel_store.sv
hw/rtl/ptpe_load_packer.sv
hw/rtl/ptpe_fetch_seq.sv
hw/rtl/planar_tile_pattern_encoder_unit.sv
sim/planar_tile_pattern_encoder_unit_tb.sv
